@@ rtl/core/pump_drive_failsafe_controller_defines.svh @@
// Assertion macros for the pump drive failsafe controller checker.
// Both macros expect signals named clk and rst_n in the scope where they are used.
`ifndef PUMP_DRIVE_FAILSAFE_CONTROLLER_DEFINES_SVH
`define PUMP_DRIVE_FAILSAFE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PDFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PDFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/pdfc_pkg.sv @@
// Shared types and constants for the pump drive failsafe controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package pdfc_pkg;

  // event modes
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_FLOW   = 2'd1;
  localparam logic [1:0] MODE_SETMAX = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_DRIVE = 2'd0;
  localparam logic [1:0] KIND_ACK   = 2'd1;
  localparam logic [1:0] KIND_HB    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_MIN     = 2'd1;
  localparam logic [1:0] CFG_PERIOD  = 2'd2;
  localparam logic [1:0] CFG_MAXRST  = 2'd3;

  // configuration reset values
  localparam logic [15:0] TIMEOUT_RST = 16'd500;
  localparam logic [19:0] MIN_RST     = 20'd100;
  localparam logic [15:0] PERIOD_RST  = 16'd200;
  localparam logic [30:0] MAX_RST     = 31'd10000;

  // held command flag bits
  localparam int unsigned FLG_AUTO = 0;
  localparam int unsigned FLG_STOP = 1;
  localparam int unsigned FLG_REV  = 2;
  localparam logic [2:0] HELD_FLAGS_RST = 3'b010;

  // status flag bits
  localparam logic [15:0] STAT_MAN_FWD  = 16'h0010;
  localparam logic [15:0] STAT_MAN_REV  = 16'h0020;
  localparam logic [15:0] STAT_ALLOWED  = 16'h0040;
  localparam logic [15:0] STAT_DRIVE_OK = 16'h0080;
  localparam logic [15:0] STAT_DIR      = 16'h0100;
  localparam logic [15:0] STAT_WIPER    = 16'h0200;

  // speed code scaling
  localparam logic [30:0] MAX_FLOOR = 31'd1000;
  localparam logic [7:0]  CODE_MAX  = 8'd255;
  localparam int unsigned DVD_W     = 39;   // target * 255 fits in 39 bits
  localparam int unsigned DVS_W     = 31;
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic busy;
    logic done;
  } div_st_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] echo_seq;
    logic [7:0]  pump_code;
    logic [15:0] status_flags;
    logic        dir_drive;
    logic        wiper_drive;
    logic [31:0] stamp_ms;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/pdfc_div.sv @@
// Serial restoring divider for the speed code: one quotient bit per cycle.
// Saturates the quotient at the code maximum. Uses pdfc_pkg.
`default_nettype none

module pdfc_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [pdfc_pkg::DVD_W-1:0]      dividend,
  input  logic [pdfc_pkg::DVS_W-1:0]      divisor,
  output pdfc_pkg::div_st_t               st,
  output logic [7:0]                      code
);
  import pdfc_pkg::*;

  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [7:0]       q_r, q_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      q_nxt    = '0;
      ovf_nxt  = 1'b0;
      cnt_nxt  = CNT_W'(DIV_STEPS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      q_nxt   = {q_r[6:0], ge};
      ovf_nxt = ovf_r | q_r[7];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    ovf_r <= ovf_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign st.busy = busy_r;
  assign st.done = done_r;
  assign code    = ovf_r ? CODE_MAX : q_r;

endmodule

`default_nettype wire

@@ rtl/core/pdfc_outreg.sv @@
// Output register for result requests, held while the receiver stalls.
// Uses res_t from pdfc_pkg.
`default_nettype none

module pdfc_outreg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  pdfc_pkg::res_t  res_in,
  input  logic            out_stall,
  output logic            out_valid,
  output pdfc_pkg::res_t  res_out,
  output logic            can_load
);
  import pdfc_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r, res_nxt;

  assign can_load = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (can_load) begin
      valid_nxt = load;
      if (load) begin
        res_nxt = res_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

`default_nettype wire

@@ rtl/core/pump_drive_failsafe_controller.sv @@
// Pump drive failsafe controller, top level: sequencer, held state, config.
// Depends on pdfc_pkg, pdfc_div and pdfc_outreg.
//
// Usage: an event request (tick, flow command or set-maximum command, with the
// switch and sense levels and a timestamp) is taken on the in_ channel when
// in_valid is high and in_stall low. Each event yields one or two result
// requests on the out_ channel, the final one marked by out_last: an ack per
// command, then a heartbeat when the status period has run out; a tick with
// no heartbeat gives one drive update, as does an unused mode. Registers must be
// written on the cfg_ channel (valid/ready, always ready) only while
// the block is idle; the block itself does not enforce this. Timing: in_stall
// is high from the cycle after acceptance until the sequencer is back in idle.
// Every event passes the command, failsafe and heartbeat states, a command
// also the ack state; a driving flow command first waits on the 39-step serial
// divider that scales the speed code. A stalled receiver holds the output
// register, and the sequencer waits in front of it with its next result.
// Reset (rst_n low, synchronous) loads the register defaults, stops the pump
// and clears any pending result.
`default_nettype none

module pump_drive_failsafe_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic [15:0]        in_seq,
  input  logic               in_flag_auto,
  input  logic               in_flag_stop,
  input  logic               in_flag_rev,
  input  logic signed [31:0] in_target_milli_lpm,
  input  logic signed [31:0] in_max_milli_lpm,
  input  logic               in_fwd_switch_low,
  input  logic               in_dir_sense_low,
  input  logic [15:0]        in_err_flags,
  input  logic [31:0]        in_time_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [15:0]        out_echo_seq,
  output logic [7:0]         out_pump_code,
  output logic [15:0]        out_status_flags,
  output logic               out_dir_drive,
  output logic               out_wiper_drive,
  output logic [31:0]        out_stamp_ms,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data
);
  import pdfc_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_CMD  = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_ACK  = 6'b001000,
    ST_FAIL = 6'b010000,
    ST_HB   = 6'b100000
  } state_t;

  state_t       state_r, state_nxt;

  // current event
  logic [1:0]   mode_r, mode_nxt;
  logic         sw_r, sw_nxt;
  logic         sense_r, sense_nxt;
  logic [15:0]  err_r, err_nxt;
  logic [31:0]  now_r, now_nxt;

  // drive and command state
  logic [7:0]   applied_code_r, applied_code_nxt;
  logic         dir_asserted_r, dir_asserted_nxt;
  logic         dir_ext_low_r, dir_ext_low_nxt;
  logic [2:0]   held_flags_r, held_flags_nxt;
  logic [31:0]  held_target_r, held_target_nxt;
  logic [31:0]  cmd_time_r, cmd_time_nxt;
  logic [15:0]  held_seq_r, held_seq_nxt;
  logic [31:0]  status_time_r, status_time_nxt;
  logic [30:0]  pump_max_r, pump_max_nxt;

  // configuration
  logic [15:0]  timeout_r, timeout_nxt;
  logic [19:0]  min_r, min_nxt;
  logic [15:0]  period_r, period_nxt;

  logic         in_acc;
  logic         manual_rev, manual_any;
  logic [31:0]  cmd_age, status_age;
  logic         held_below_min, allowed_now, hb_due;
  logic [30:0]  max_eff;
  logic [DVD_W-1:0] dividend;
  logic         div_start;
  div_st_t      div_st;
  logic [7:0]   div_code;
  logic         res_load, can_load;
  res_t         res_in, res_out;
  logic [1:0]   res_kind;
  logic [31:0]  res_stamp;
  logic         res_last;
  logic [15:0]  flags;
  logic [31:0]  new_max;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign manual_rev = sense_r && (!dir_asserted_r || dir_ext_low_r);
  assign manual_any = sw_r || manual_rev;

  assign cmd_age        = now_r - cmd_time_r;
  assign status_age     = now_r - status_time_r;
  assign held_below_min = held_target_r[31] || (held_target_r < {12'd0, min_r});
  assign allowed_now    = (cmd_age <= {16'd0, timeout_r}) && held_flags_r[FLG_AUTO]
                          && !held_flags_r[FLG_STOP] && !held_below_min;
  assign hb_due         = (status_age >= {16'd0, period_r});

  // target * 255 as (target << 8) - target; target is non-negative here
  assign max_eff  = (pump_max_r < MAX_FLOOR) ? MAX_FLOOR : pump_max_r;
  assign dividend = {held_target_r[30:0], 8'd0} - {8'd0, held_target_r[30:0]};
  assign new_max  = $unsigned(in_max_milli_lpm);

  always_comb begin
    flags = err_r;
    if (sw_r)                               flags = flags | STAT_MAN_FWD;
    if (manual_rev)                         flags = flags | STAT_MAN_REV;
    if (allowed_now)                        flags = flags | STAT_ALLOWED;
    if (allowed_now && !sw_r && !manual_rev) flags = flags | STAT_DRIVE_OK;
    if (dir_asserted_r)                     flags = flags | STAT_DIR;
    if (!manual_any)                        flags = flags | STAT_WIPER;
  end

  always_comb begin
    res_in.kind         = res_kind;
    res_in.echo_seq     = held_seq_r;
    res_in.pump_code    = applied_code_r;
    res_in.status_flags = flags;
    res_in.dir_drive    = dir_asserted_r;
    res_in.wiper_drive  = !manual_any;
    res_in.stamp_ms     = res_stamp;
    res_in.last         = res_last;
  end

  always_comb begin
    state_nxt        = state_r;
    mode_nxt         = mode_r;
    sw_nxt           = sw_r;
    sense_nxt        = sense_r;
    err_nxt          = err_r;
    now_nxt          = now_r;
    applied_code_nxt = applied_code_r;
    dir_asserted_nxt = dir_asserted_r;
    dir_ext_low_nxt  = dir_ext_low_r;
    held_flags_nxt   = held_flags_r;
    held_target_nxt  = held_target_r;
    cmd_time_nxt     = cmd_time_r;
    held_seq_nxt     = held_seq_r;
    status_time_nxt  = status_time_r;
    pump_max_nxt     = pump_max_r;
    timeout_nxt      = timeout_r;
    min_nxt          = min_r;
    period_nxt       = period_r;
    div_start        = 1'b0;
    res_load         = 1'b0;
    res_kind         = KIND_DRIVE;
    res_stamp        = '0;
    res_last         = 1'b1;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_TIMEOUT: timeout_nxt  = cfg_data[15:0];
        CFG_MIN:     min_nxt      = cfg_data[19:0];
        CFG_PERIOD:  period_nxt   = cfg_data[15:0];
        CFG_MAXRST:  pump_max_nxt = cfg_data;
        default:     ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          mode_nxt  = in_mode;
          sw_nxt    = in_fwd_switch_low;
          sense_nxt = in_dir_sense_low;
          err_nxt   = in_err_flags;
          now_nxt   = in_time_ms;
          // store the command right away; the apply step follows
          if (in_mode == MODE_FLOW) begin
            held_seq_nxt    = in_seq;
            cmd_time_nxt    = in_time_ms;
            held_flags_nxt  = {in_flag_rev, in_flag_stop, in_flag_auto};
            held_target_nxt = $unsigned(in_target_milli_lpm);
          end else if (in_mode == MODE_SETMAX) begin
            held_seq_nxt = in_seq;
            cmd_time_nxt = in_time_ms;
            if (new_max[31] || (new_max[30:0] < MAX_FLOOR)) begin
              pump_max_nxt = MAX_FLOOR;
            end else begin
              pump_max_nxt = new_max[30:0];
            end
          end
          state_nxt = ST_CMD;
        end
      end
      ST_CMD: begin
        if (mode_r == MODE_FLOW) begin
          if (manual_any || !allowed_now) begin
            applied_code_nxt = '0;
            dir_asserted_nxt = 1'b0;
            dir_ext_low_nxt  = 1'b0;
            state_nxt        = ST_ACK;
          end else begin
            dir_ext_low_nxt  = held_flags_r[FLG_REV] && sense_r;
            dir_asserted_nxt = held_flags_r[FLG_REV] && !sense_r;
            // sense low leaves manual reverse active: hold the code at zero
            if (sense_r) begin
              applied_code_nxt = '0;
              state_nxt        = ST_ACK;
            end else begin
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end
          end
        end else if (mode_r == MODE_SETMAX) begin
          state_nxt = ST_ACK;
        end else begin
          state_nxt = ST_FAIL;
        end
      end
      ST_DIV: begin
        if (div_st.done) begin
          applied_code_nxt = div_code;
          state_nxt        = ST_ACK;
        end
      end
      ST_ACK: begin
        res_kind = KIND_ACK;
        res_last = !hb_due;
        if (can_load) begin
          res_load  = 1'b1;
          state_nxt = ST_FAIL;
        end
      end
      ST_FAIL: begin
        if (manual_any || !allowed_now) begin
          applied_code_nxt = '0;
          dir_asserted_nxt = 1'b0;
          dir_ext_low_nxt  = 1'b0;
        end
        state_nxt = ST_HB;
      end
      ST_HB: begin
        if (hb_due) begin
          res_kind  = KIND_HB;
          res_stamp = now_r;
          if (can_load) begin
            res_load        = 1'b1;
            status_time_nxt = now_r;
            state_nxt       = ST_IDLE;
          end
        end else if (mode_r != MODE_FLOW && mode_r != MODE_SETMAX) begin
          res_kind = KIND_DRIVE;
          if (can_load) begin
            res_load  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    mode_r        <= mode_nxt;
    sw_r          <= sw_nxt;
    sense_r       <= sense_nxt;
    err_r         <= err_nxt;
    now_r         <= now_nxt;
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      applied_code_r <= '0;
      dir_asserted_r <= 1'b0;
      dir_ext_low_r  <= 1'b0;
      held_flags_r   <= HELD_FLAGS_RST;
      held_target_r  <= '0;
      cmd_time_r     <= '0;
      held_seq_r     <= '0;
      status_time_r  <= '0;
      pump_max_r     <= MAX_RST;
      timeout_r      <= TIMEOUT_RST;
      min_r          <= MIN_RST;
      period_r       <= PERIOD_RST;
    end else begin
      state_r        <= state_nxt;
      applied_code_r <= applied_code_nxt;
      dir_asserted_r <= dir_asserted_nxt;
      dir_ext_low_r  <= dir_ext_low_nxt;
      held_flags_r   <= held_flags_nxt;
      held_target_r  <= held_target_nxt;
      cmd_time_r     <= cmd_time_nxt;
      held_seq_r     <= held_seq_nxt;
      status_time_r  <= status_time_nxt;
      pump_max_r     <= pump_max_nxt;
      timeout_r      <= timeout_nxt;
      min_r          <= min_nxt;
      period_r       <= period_nxt;
    end
  end

  pdfc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (max_eff),
    .st       (div_st),
    .code     (div_code)
  );

  pdfc_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_load),
    .res_in    (res_in),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_out   (res_out),
    .can_load  (can_load)
  );

  assign out_kind         = res_out.kind;
  assign out_echo_seq     = res_out.echo_seq;
  assign out_pump_code    = res_out.pump_code;
  assign out_status_flags = res_out.status_flags;
  assign out_dir_drive    = res_out.dir_drive;
  assign out_wiper_drive  = res_out.wiper_drive;
  assign out_stamp_ms     = res_out.stamp_ms;
  assign out_last         = res_out.last;

endmodule

`default_nettype wire

@@ rtl/core/pdfc_checker.sv @@
// Port-level checker for the pump drive failsafe controller, bound to the top.
// Depends on pdfc_pkg and the assertion macros in the defines header.
`default_nettype none
`include "pump_drive_failsafe_controller_defines.svh"

module pdfc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [15:0] out_echo_seq,
  input logic [7:0]  out_pump_code,
  input logic [15:0] out_status_flags,
  input logic        out_dir_drive,
  input logic        out_wiper_drive,
  input logic [31:0] out_stamp_ms,
  input logic        out_last
);
  import pdfc_pkg::*;

  // a stalled result request holds its payload
  `PDFC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_kind) && $stable(out_echo_seq) && $stable(out_pump_code) && $stable(out_status_flags) && $stable(out_dir_drive) && $stable(out_wiper_drive) && $stable(out_stamp_ms) && $stable(out_last), "stalled result changed")

  // the block is busy right after taking an event
  `PDFC_ASSERT_NXT(a_busy_after_acc, in_valid && !in_stall, in_stall, "ready right after accept")

  // only an ack may be followed by another result of the same event
  `PDFC_ASSERT_IMP(a_last_non_ack, out_valid && out_kind != KIND_ACK, out_last, "non-ack result without last")

  // only a heartbeat carries a timestamp
  `PDFC_ASSERT_IMP(a_stamp_hb_only, out_valid && out_kind != KIND_HB, out_stamp_ms == 32'd0, "stamp outside heartbeat")

endmodule

bind pump_drive_failsafe_controller pdfc_checker u_pdfc_checker (.*);

`default_nettype wire

@@ bench/pump_drive_failsafe_controller_checker.sv @@
// Result checker for pump_drive_failsafe_controller: follows the event, result and
// register channels, predicts every result request and compares it in order.
// Depends on pdfc_pkg; instantiated next to the block by the testbench top.
module pump_drive_failsafe_controller_checker
  import pdfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_seq,
  input  logic        in_flag_auto,
  input  logic        in_flag_stop,
  input  logic        in_flag_rev,
  input  logic [31:0] in_target_milli_lpm,
  input  logic [31:0] in_max_milli_lpm,
  input  logic        in_fwd_switch_low,
  input  logic        in_dir_sense_low,
  input  logic [15:0] in_err_flags,
  input  logic [31:0] in_time_ms,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic [15:0] out_echo_seq,
  input  logic [7:0]  out_pump_code,
  input  logic [15:0] out_status_flags,
  input  logic        out_dir_drive,
  input  logic        out_wiper_drive,
  input  logic [31:0] out_stamp_ms,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  output int          mismatch_count,
  output int          results_pending,
  output int          results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SHOWN_ERRORS = 10;

  // register copies
  logic [15:0] timeout_ms;
  logic [19:0] min_lpm;
  logic [15:0] period_ms;

  // drive state
  logic [7:0]  code_q;
  logic        dir_on;
  logic        dir_ext_low;
  logic        rev_on;
  logic [2:0]  cmd_flags;
  logic [31:0] cmd_target;
  logic [31:0] cmd_stamp;
  logic [15:0] cmd_seq;
  logic [31:0] hb_stamp;
  logic [31:0] max_flow;

  // levels sampled with the current event
  logic        fwd_sw;
  logic        sense_lo;
  logic [15:0] link_err;

  res_t        expected_results[$];
  res_t        batch[2];
  res_t        seen;
  res_t        want_r;
  logic [31:0] now;
  logic [31:0] new_max;
  int          n_batch;
  int          err_cnt = 0;
  int          res_cnt = 0;

  function automatic logic below_floor(input logic [31:0] t);
    return t[31] || (t < {12'd0, min_lpm});
  endfunction

  // direction line held low from outside while not driven by us
  function automatic logic sense_override();
    return sense_lo && (!dir_on || dir_ext_low);
  endfunction

  function automatic logic manual_override();
    return fwd_sw || sense_override();
  endfunction

  function automatic logic drive_permitted(input logic [31:0] t_now);
    logic [31:0] age;
    age = t_now - cmd_stamp;
    if (age > {16'd0, timeout_ms}) return 1'b0;
    if (!cmd_flags[FLG_AUTO] || cmd_flags[FLG_STOP]) return 1'b0;
    return !below_floor(cmd_target);
  endfunction

  function automatic void steer(input logic rev);
    dir_ext_low = rev && sense_lo;
    dir_on      = rev && !sense_lo;
  endfunction

  function automatic logic [7:0] scaled_code(input logic [31:0] t);
    logic [63:0] dvs;
    logic [63:0] q;
    if (below_floor(t)) return 8'd0;
    dvs = (max_flow < {1'b0, MAX_FLOOR}) ? {33'd0, MAX_FLOOR} : {32'd0, max_flow};
    q = ({32'd0, t} * {56'd0, CODE_MAX}) / dvs;
    return (q > {56'd0, CODE_MAX}) ? CODE_MAX : q[7:0];
  endfunction

  function automatic void halt_pump();
    code_q = 8'd0;
    steer(1'b0);
    rev_on = 1'b0;
  endfunction

  function automatic void apply_flow(input logic [31:0] t_now);
    logic want;
    if (manual_override() || !drive_permitted(t_now)) begin
      halt_pump();
      return;
    end
    want = cmd_flags[FLG_REV];
    // stop before a reversal
    if (want != rev_on) begin
      code_q = 8'd0;
      steer(1'b0);
    end
    steer(want);
    rev_on = want && dir_on;
    if (manual_override()) begin
      code_q = 8'd0;
      return;
    end
    code_q = scaled_code(cmd_target);
  endfunction

  function automatic logic [15:0] status_word(input logic [31:0] t_now);
    logic        mf;
    logic        mr;
    logic        ok;
    logic [15:0] w;
    mf = fwd_sw;
    mr = sense_override();
    ok = drive_permitted(t_now);
    w  = link_err;
    if (mf) w |= STAT_MAN_FWD;
    if (mr) w |= STAT_MAN_REV;
    if (ok) w |= STAT_ALLOWED;
    if (ok && !mf && !mr) w |= STAT_DRIVE_OK;
    if (dir_on) w |= STAT_DIR;
    if (!(mf || mr)) w |= STAT_WIPER;
    return w;
  endfunction

  function automatic res_t snapshot(input logic [1:0] kind, input logic [15:0] seq,
                                    input logic [31:0] t_now, input logic [31:0] stamp);
    res_t r;
    r.kind         = kind;
    r.echo_seq     = seq;
    r.pump_code    = code_q;
    r.status_flags = status_word(t_now);
    r.dir_drive    = dir_on;
    r.wiper_drive  = !manual_override();
    r.stamp_ms     = stamp;
    r.last         = 1'b0;
    return r;
  endfunction

  function automatic string show(input res_t r);
    return $sformatf("kind %0d seq %h code %0d flags %h dir %b wiper %b stamp %h last %b",
                     r.kind, r.echo_seq, r.pump_code, r.status_flags, r.dir_drive,
                     r.wiper_drive, r.stamp_ms, r.last);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      timeout_ms  = TIMEOUT_RST;
      min_lpm     = MIN_RST;
      period_ms   = PERIOD_RST;
      max_flow    = {1'b0, MAX_RST};
      code_q      = 8'd0;
      dir_on      = 1'b0;
      dir_ext_low = 1'b0;
      rev_on      = 1'b0;
      cmd_flags   = HELD_FLAGS_RST;
      cmd_target  = 32'd0;
      cmd_stamp   = 32'd0;
      cmd_seq     = 16'd0;
      hb_stamp    = 32'd0;
      fwd_sw      = 1'b0;
      sense_lo    = 1'b0;
      link_err    = 16'd0;
      expected_results.delete();
    end else begin
      // check results before queuing new ones: an event never answers in its own cycle
      if (out_valid && !out_stall) begin
        seen.kind         = out_kind;
        seen.echo_seq     = out_echo_seq;
        seen.pump_code    = out_pump_code;
        seen.status_flags = out_status_flags;
        seen.dir_drive    = out_dir_drive;
        seen.wiper_drive  = out_wiper_drive;
        seen.stamp_ms     = out_stamp_ms;
        seen.last         = out_last;
        res_cnt++;
        if (expected_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= SHOWN_ERRORS)
            $display("%0t: result %0d with nothing expected: %s", $time, res_cnt, show(seen));
        end else begin
          want_r = expected_results.pop_front();
          if (seen !== want_r) begin
            err_cnt++;
            if (err_cnt <= SHOWN_ERRORS) begin
              $display("%0t: result %0d mismatch", $time, res_cnt);
              $display("  expected %s", show(want_r));
              $display("  actual   %s", show(seen));
            end
          end
        end
      end

      if (in_valid && !in_stall) begin
        n_batch  = 0;
        now      = in_time_ms;
        fwd_sw   = in_fwd_switch_low;
        sense_lo = in_dir_sense_low;
        link_err = in_err_flags;
        if (in_mode == MODE_FLOW) begin
          cmd_seq             = in_seq;
          cmd_stamp           = now;
          cmd_flags[FLG_AUTO] = in_flag_auto;
          cmd_flags[FLG_STOP] = in_flag_stop;
          cmd_flags[FLG_REV]  = in_flag_rev;
          cmd_target          = in_target_milli_lpm;
          apply_flow(now);
          batch[n_batch] = snapshot(KIND_ACK, in_seq, now, 32'd0);
          n_batch++;
        end else if (in_mode == MODE_SETMAX) begin
          new_max = in_max_milli_lpm;
          if (new_max[31] || new_max < {1'b0, MAX_FLOOR}) new_max = {1'b0, MAX_FLOOR};
          max_flow  = new_max;
          cmd_seq   = in_seq;
          cmd_stamp = now;
          batch[n_batch] = snapshot(KIND_ACK, in_seq, now, 32'd0);
          n_batch++;
        end
        // failsafe check runs on every event, commands included
        if (manual_override() || !drive_permitted(now)) halt_pump();
        if ((now - hb_stamp) >= {16'd0, period_ms}) begin
          hb_stamp = now;
          batch[n_batch] = snapshot(KIND_HB, cmd_seq, now, now);
          n_batch++;
        end
        if (n_batch == 0) begin
          batch[n_batch] = snapshot(KIND_DRIVE, cmd_seq, now, 32'd0);
          n_batch++;
        end
        batch[n_batch - 1].last = 1'b1;
        for (int k = 0; k < n_batch; k++) expected_results.push_back(batch[k]);
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TIMEOUT: timeout_ms = cfg_data[15:0];
          CFG_MIN:     min_lpm    = cfg_data[19:0];
          CFG_PERIOD:  period_ms  = cfg_data[15:0];
          CFG_MAXRST:  max_flow   = {1'b0, cfg_data};
          default: ;
        endcase
      end
    end
    mismatch_count  <= err_cnt;
    results_pending <= expected_results.size();
    results_checked <= res_cnt;
  end

endmodule

@@ bench/pump_drive_failsafe_controller_tb.sv @@
// Testbench top for pump_drive_failsafe_controller: directed events, then random
// event traffic over several register settings with sender gaps and receiver stalls.
// Depends on pdfc_pkg, the block RTL and pump_drive_failsafe_controller_checker.
module pump_drive_failsafe_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pdfc_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 241;
  localparam int DRAIN_CYCLES  = 60;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_pattern_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] seq;
    logic        auto_f;
    logic        stop_f;
    logic        rev_f;
    logic [31:0] target;
    logic [31:0] maxf;
    logic        fwd_low;
    logic        sense_low;
    logic [15:0] err;
    logic [31:0] stamp;
  } pump_event_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_mode;
  logic [15:0]        in_seq;
  logic               in_flag_auto;
  logic               in_flag_stop;
  logic               in_flag_rev;
  logic signed [31:0] in_target_milli_lpm;
  logic signed [31:0] in_max_milli_lpm;
  logic               in_fwd_switch_low;
  logic               in_dir_sense_low;
  logic [15:0]        in_err_flags;
  logic [31:0]        in_time_ms;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_kind;
  logic [15:0]        out_echo_seq;
  logic [7:0]         out_pump_code;
  logic [15:0]        out_status_flags;
  logic               out_dir_drive;
  logic               out_wiper_drive;
  logic [31:0]        out_stamp_ms;
  logic               out_last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [30:0]        cfg_data;
  int                 mismatch_count;
  int                 results_pending;
  int                 results_checked;

  // stimulus shaping: rough view of what the block holds
  logic [31:0]    cur_time    = 32'd0;
  longint         cur_max     = 10000;
  int unsigned    cur_min     = 100;
  logic           cur_rev     = 1'b0;
  int             burst_left  = 0;
  int             n_flow      = 0;
  int             n_setmax    = 0;
  int             n_tick      = 0;
  int             n_settings  = 1;
  int             cycle_cnt   = 0;
  stall_pattern_t stall_mode  = STALL_NONE;
  int             stall_left  = 0;
  int             stall_phase = 0;

  pump_event_t    ev;
  int             pick;
  int             roll;
  logic [31:0]    dt;
  longint         hi;

  pump_drive_failsafe_controller u_dut (.*);

  pump_drive_failsafe_controller_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_cnt, results_pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: switch at random between stall patterns
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_pattern_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(40, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_phase <= (stall_phase == 6) ? 0 : stall_phase + 1;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 20);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 65);
      default:     out_stall <= (stall_phase < 3);
    endcase
  end

  function automatic pump_event_t plain_event(input logic [1:0] mode, input logic [31:0] stamp,
                                              input logic [31:0] value);
    pump_event_t e;
    e        = '0;
    e.mode   = mode;
    e.stamp  = stamp;
    e.seq    = stamp[15:0] + 16'h0100;
    e.auto_f = 1'b1;
    e.target = value;
    e.maxf   = value;
    return e;
  endfunction

  task automatic send_event(input pump_event_t e);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 2) ? $urandom_range(10, 40) : $urandom_range(0, 5);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid            <= 1'b1;
    in_mode             <= e.mode;
    in_seq              <= e.seq;
    in_flag_auto        <= e.auto_f;
    in_flag_stop        <= e.stop_f;
    in_flag_rev         <= e.rev_f;
    in_target_milli_lpm <= e.target;
    in_max_milli_lpm    <= e.maxf;
    in_fwd_switch_low   <= e.fwd_low;
    in_dir_sense_low    <= e.sense_low;
    in_err_flags        <= e.err;
    in_time_ms          <= e.stamp;
    do @(posedge clk); while (in_stall);
    cur_time = e.stamp;
    case (e.mode)
      MODE_FLOW: n_flow++;
      MODE_SETMAX: begin
        n_setmax++;
        cur_max = (e.maxf[31] || e.maxf < {1'b0, MAX_FLOOR}) ? MAX_FLOOR : e.maxf;
      end
      default: n_tick++;
    endcase
  endtask

  // hold off until every expected result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  task automatic program_regs(input int unsigned tmo, input int unsigned min_v,
                              input int unsigned per, input int unsigned maxr);
    logic [30:0] regv[4];
    regv[CFG_TIMEOUT] = tmo;
    regv[CFG_MIN]     = min_v;
    regv[CFG_PERIOD]  = per;
    regv[CFG_MAXRST]  = maxr;
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(k);
      cfg_data  <= regv[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_min = min_v;
    cur_max = maxr;
    n_settings++;
  endtask

  initial begin
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_mode             = MODE_TICK;
    in_seq              = 16'd0;
    in_flag_auto        = 1'b0;
    in_flag_stop        = 1'b0;
    in_flag_rev         = 1'b0;
    in_target_milli_lpm = 32'sd0;
    in_max_milli_lpm    = 32'sd0;
    in_fwd_switch_low   = 1'b0;
    in_dir_sense_low    = 1'b0;
    in_err_flags        = 16'd0;
    in_time_ms          = 32'd0;
    cfg_valid           = 1'b0;
    cfg_index           = CFG_TIMEOUT;
    cfg_data            = 31'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed events on the reset register values
    ev = plain_event(MODE_TICK, 32'd0, 32'd0); send_event(ev);
    ev = plain_event(MODE_SETMAX, 32'd5, 32'hFFFF_FFFB); send_event(ev);
    ev = plain_event(MODE_SETMAX, 32'd6, 32'd999); send_event(ev);
    ev = plain_event(MODE_SETMAX, 32'd7, 32'h7FFF_FFFF); send_event(ev);
    ev = plain_event(MODE_SETMAX, 32'd8, 32'd20000); ev.seq = 16'hFFFF; send_event(ev);
    ev = plain_event(MODE_FLOW, 32'd10, 32'd10000); send_event(ev);
    ev = plain_event(MODE_FLOW, 32'd12, 32'd20000);
    ev.rev_f = 1'b1;
    ev.sense_low = 1'b1;
    send_event(ev);
    ev = plain_event(MODE_FLOW, 32'd14, 32'd30000); ev.rev_f = 1'b1; send_event(ev);
    ev = plain_event(MODE_FLOW, 32'd16, 32'd5000); send_event(ev);
    ev = plain_event(MODE_FLOW, 32'd18, 32'd5000); ev.stop_f = 1'b1; send_event(ev);
    ev = plain_event(MODE_FLOW, 32'd20, 32'd5000); ev.auto_f = 1'b0; send_event(ev);
    ev = plain_event(MODE_FLOW, 32'd22, 32'h8000_0000); send_event(ev);
    ev = plain_event(MODE_FLOW, 32'd24, 32'h7FFF_FFFF); send_event(ev);
    ev = plain_event(MODE_FLOW, 32'd26, 32'd99); send_event(ev);
    ev = plain_event(MODE_FLOW, 32'd28, 32'd100); send_event(ev);
    ev = plain_event(MODE_FLOW, 32'd30, 32'd8000); ev.fwd_low = 1'b1; send_event(ev);
    ev = plain_event(MODE_FLOW, 32'd32, 32'd8000); send_event(ev);
    ev = plain_event(MODE_TICK, 32'd33, 32'd0); ev.sense_low = 1'b1; send_event(ev);
    ev = plain_event(MODE_UNUSED, 32'd34, 32'd0); ev.err = 16'hFFFF; send_event(ev);
    ev = plain_event(MODE_TICK, 32'd250, 32'd0); send_event(ev);
    ev = plain_event(MODE_TICK, 32'd700, 32'd0); send_event(ev);
    ev = plain_event(MODE_FLOW, 32'hFFFF_FF00, 32'd9000); ev.rev_f = 1'b1; send_event(ev);
    ev = plain_event(MODE_TICK, 32'h0000_0050, 32'd0); send_event(ev);
    ev = plain_event(MODE_FLOW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    ev.seq       = 16'hFFFF;
    ev.stop_f    = 1'b1;
    ev.rev_f     = 1'b1;
    ev.fwd_low   = 1'b1;
    ev.sense_low = 1'b1;
    ev.err       = 16'hFFFF;
    send_event(ev);
    drain();

    for (int p = 1; p <= RANDOM_PHASES; p++) begin
      case (p)
        1: program_regs(32'h0000_FFFF, 0, 1, 1000);
        2: program_regs(0, 1000000, 32'h0000_FFFF, 32'h7FFF_FFFF);
        default: program_regs($urandom_range(20, 1500), $urandom_range(0, 4000),
                              $urandom_range(1, 600), $urandom_range(1000, 400000));
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 10) dt = 32'd0;
        else if (roll < 70) dt = $urandom_range(1, 50);
        else if (roll < 90) dt = $urandom_range(51, 400);
        else if (roll < 97) dt = $urandom_range(401, 70000);
        else dt = $urandom();
        // unused fields carry noise
        ev           = plain_event(MODE_TICK, cur_time + dt, $urandom());
        ev.maxf      = $urandom();
        ev.seq       = $urandom();
        ev.auto_f    = $urandom();
        ev.stop_f    = $urandom();
        ev.rev_f     = $urandom();
        ev.err       = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'd0;
        ev.fwd_low   = ($urandom_range(0, 99) < 8);
        ev.sense_low = ($urandom_range(0, 99) < 15);
        pick = $urandom_range(0, 99);
        if (pick < 42) begin
          ev.mode = MODE_FLOW;
          if ($urandom_range(0, 3) == 0) cur_rev = !cur_rev;
          ev.auto_f = ($urandom_range(0, 99) < 90);
          ev.stop_f = ($urandom_range(0, 99) < 8);
          ev.rev_f  = cur_rev;
          hi = cur_max + cur_max / 4;
          if (hi > 64'h7FFF_FFFF) hi = 64'h7FFF_FFFF;
          roll = $urandom_range(0, 99);
          if (roll < 72) ev.target = $urandom_range(cur_min, 32'(hi));
          else if (roll < 84) ev.target = $urandom_range(0, cur_min);
          else if (roll < 94) ev.target = $urandom();
          else begin
            case ($urandom_range(0, 3))
              0: ev.target = 32'h0000_0000;
              1: ev.target = 32'h7FFF_FFFF;
              2: ev.target = 32'h8000_0000;
              default: ev.target = 32'hFFFF_FFFF;
            endcase
          end
        end else if (pick < 50) begin
          ev.mode = MODE_SETMAX;
          roll = $urandom_range(0, 99);
          if (roll < 70) ev.maxf = $urandom_range(1000, 200000);
          else if (roll < 82) ev.maxf = $urandom_range(0, 999);
          else if (roll < 92) ev.maxf = $urandom();
          else begin
            case ($urandom_range(0, 3))
              0: ev.maxf = 32'h8000_0000;
              1: ev.maxf = 32'h7FFF_FFFF;
              2: ev.maxf = 32'hFFFF_FFFF;
              default: ev.maxf = {1'b0, MAX_FLOOR};
            endcase
          end
        end else if (pick < 52) begin
          ev.mode = MODE_UNUSED;
        end
        send_event(ev);
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d events (%0d flow, %0d set-maximum, %0d tick) over %0d register settings",
             n_flow + n_setmax + n_tick, n_flow, n_setmax, n_tick, n_settings);
    $display("Compared %0d results, %0d mismatched", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/pdfc_pkg.sv
rtl/core/pdfc_div.sv
rtl/core/pdfc_outreg.sv
rtl/core/pump_drive_failsafe_controller.sv
rtl/core/pdfc_checker.sv
bench/pump_drive_failsafe_controller_checker.sv
bench/pump_drive_failsafe_controller_tb.sv
